// ===== rtl/core/hsfd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsfd_pkg: shared types and constants of the heater status frame decoder
//
// Holds the beat payload structs, the capture state struct, the byte offsets
// of the frame fields and the codes for frame kind and run class.
// ----------------------------------------------------------------------------
package hsfd_pkg;

   // Frame length limits.
   localparam int unsigned STATUS_FRAME_BYTES = 52;
   localparam int unsigned BASIC_FRAME_BYTES  = 8;
   localparam int unsigned IDX_W              = 6;

   localparam logic [IDX_W-1:0] STATUS_LEN = IDX_W'(STATUS_FRAME_BYTES);
   localparam logic [IDX_W-1:0] BASIC_LEN  = IDX_W'(BASIC_FRAME_BYTES);

   // Byte offsets of the captured fields.
   localparam logic [IDX_W-1:0] OFS_LEAD0 = 6'd0;
   localparam logic [IDX_W-1:0] OFS_LEAD1 = 6'd1;
   localparam logic [IDX_W-1:0] OFS_LEAD2 = 6'd2;
   localparam logic [IDX_W-1:0] OFS_SEQ   = 6'd3;
   localparam logic [IDX_W-1:0] OFS_PHASE = 6'd9;
   localparam logic [IDX_W-1:0] OFS_VOLT  = 6'd10;
   localparam logic [IDX_W-1:0] OFS_STEP  = 6'd14;
   localparam logic [IDX_W-1:0] OFS_TEMP  = 6'd16;
   localparam logic [IDX_W-1:0] OFS_FAN_L = 6'd20;
   localparam logic [IDX_W-1:0] OFS_FAN_H = 6'd21;
   localparam logic [IDX_W-1:0] OFS_PMP_L = 6'd22;
   localparam logic [IDX_W-1:0] OFS_PMP_H = 6'd23;
   localparam logic [IDX_W-1:0] OFS_HOURS = 6'd41;

   // Header and phase byte values.
   localparam logic [7:0] HDR_AA        = 8'hAA;
   localparam logic [7:0] HDR_09        = 8'h09;
   localparam logic [7:0] HDR_FF        = 8'hFF;
   localparam logic [7:0] HDR_55        = 8'h55;
   localparam logic [7:0] HDR_AB        = 8'hAB;
   localparam logic [7:0] HDR_BA        = 8'hBA;
   localparam logic [7:0] PHASE_OFF     = 8'h40;
   localparam logic [7:0] PHASE_START   = 8'hC0;
   localparam logic [7:0] PHASE_HEAT_A  = 8'hC4;
   localparam logic [7:0] PHASE_HEAT_B  = 8'hCC;

   // Reciprocal of 100 scaled by 2^23; exact floor for any 16-bit value.
   localparam int unsigned PUMP_SHIFT   = 23;
   localparam logic [16:0] PUMP_RECIP   = 17'd83887;

   // Frame kind codes.
   localparam logic [1:0] KIND_STATUS  = 2'd0;
   localparam logic [1:0] KIND_BASIC   = 2'd1;
   localparam logic [1:0] KIND_ABBA    = 2'd2;
   localparam logic [1:0] KIND_UNKNOWN = 2'd3;

   // Run class codes.
   localparam logic [2:0] RUN_OFF       = 3'd0;
   localparam logic [2:0] RUN_PREPARING = 3'd1;
   localparam logic [2:0] RUN_STARTING  = 3'd2;
   localparam logic [2:0] RUN_HEATING   = 3'd3;
   localparam logic [2:0] RUN_COOLING   = 3'd4;

   // Input beat.
   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_frame;
   } req_type;

   // Result beat.
   typedef struct packed {
      logic [1:0]  frame_kind;
      logic        heater_on;
      logic [2:0]  run_class;
      logic [7:0]  ignition_step;
      logic [7:0]  battery_decivolts;
      logic [7:0]  room_decidegrees;
      logic [15:0] fan_speed;
      logic [15:0] pump_count;
      logic [9:0]  pump_rate;
      logic [7:0]  hours_run;
      logic [7:0]  sequence_number;
   } rsp_type;

   // Capture state of one frame.
   typedef struct packed {
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       lead0;
      logic [7:0]       lead1;
      logic [7:0]       lead2;
      logic [7:0]       seq_hold;
      logic [7:0]       phase_hold;
      logic [7:0]       volt_hold;
      logic [7:0]       step_hold;
      logic [7:0]       temp_hold;
      logic [15:0]      fan_hold;
      logic [15:0]      pump_hold;
      logic [7:0]       hours_hold;
   } frame_type;

endpackage : hsfd_pkg
`default_nettype wire

// ===== rtl/core/heater_status_frame_decoder.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// heater_status_frame_decoder: sorts and decodes heater notification frames
//
// The block takes one notification byte per beat and accepts a byte in every
// cycle. Each byte is captured into the frame state in the cycle it arrives.
// The last byte of a notification copies the completed frame state into a
// snapshot register and clears the capture state, so the next notification
// may start in the very next cycle. The snapshot is then classified, the pump
// rate is formed by a single 16x17 reciprocal multiply, and the result is
// loaded into the output register as soon as that register is empty or is
// being taken; the result beat is offered from there and waits while the
// receiver stalls. The input stalls only when the snapshot is full and the
// output register cannot take it.
// ----------------------------------------------------------------------------
module heater_status_frame_decoder
   import hsfd_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   frame_type  frm_ff, frm_in, frm_upd;
   frame_type  snap_ff, snap_in;
   logic       snap_vld_ff, snap_vld_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       req_acc, last_acc, res_load;
   logic [IDX_W-1:0] pos;
   logic [32:0]      pump_prod;
   logic             is_status, is_basic, is_abba;

   // Handshake control.
   assign res_load  = snap_vld_ff && (!rsp_vld_ff || !rsp_stall);
   assign req_stall = snap_vld_ff && !res_load;
   assign req_acc   = req_valid && !req_stall;
   assign last_acc  = req_acc && req_data.end_of_frame;

   // Capture the current byte at its offset while the count is unsaturated.
   always_comb begin
      frm_upd = frm_ff;
      pos     = frm_ff.byte_index;
      if (pos < STATUS_LEN) begin
         if (pos == OFS_LEAD0) frm_upd.lead0      = req_data.rx_byte;
         if (pos == OFS_LEAD1) frm_upd.lead1      = req_data.rx_byte;
         if (pos == OFS_LEAD2) frm_upd.lead2      = req_data.rx_byte;
         if (pos == OFS_SEQ)   frm_upd.seq_hold   = req_data.rx_byte;
         if (pos == OFS_PHASE) frm_upd.phase_hold = req_data.rx_byte;
         if (pos == OFS_VOLT)  frm_upd.volt_hold  = req_data.rx_byte;
         if (pos == OFS_STEP)  frm_upd.step_hold  = req_data.rx_byte;
         if (pos == OFS_TEMP)  frm_upd.temp_hold  = req_data.rx_byte;
         if (pos == OFS_FAN_L) frm_upd.fan_hold[7:0]   = req_data.rx_byte;
         if (pos == OFS_FAN_H) frm_upd.fan_hold[15:8]  = req_data.rx_byte;
         if (pos == OFS_PMP_L) frm_upd.pump_hold[7:0]  = req_data.rx_byte;
         if (pos == OFS_PMP_H) frm_upd.pump_hold[15:8] = req_data.rx_byte;
         if (pos == OFS_HOURS) frm_upd.hours_hold = req_data.rx_byte;
         frm_upd.byte_index = pos + IDX_W'(1);
      end
   end

   // Capture state: cleared after the last byte, else updated per beat.
   always_comb begin
      frm_in = frm_ff;
      if (last_acc) begin
         frm_in = '0;
      end else if (req_acc) begin
         frm_in = frm_upd;
      end
   end

   // Snapshot stage holds one completed frame.
   always_comb begin
      snap_in     = snap_ff;
      snap_vld_in = snap_vld_ff;
      if (last_acc) begin
         snap_in     = frm_upd;
         snap_vld_in = 1'b1;
      end else if (res_load) begin
         snap_vld_in = 1'b0;
      end
   end

   // Frame classification from header and length.
   assign is_status = (snap_ff.byte_index >= STATUS_LEN) && (snap_ff.lead0 == HDR_AA) &&
                      (snap_ff.lead1 == HDR_09) && (snap_ff.lead2 == HDR_FF);
   assign is_basic  = (snap_ff.byte_index >= BASIC_LEN) && (snap_ff.lead0 == HDR_AA) &&
                      (snap_ff.lead1 == HDR_55);
   assign is_abba   = (snap_ff.byte_index >= BASIC_LEN) && (snap_ff.lead0 == HDR_AB) &&
                      (snap_ff.lead1 == HDR_BA);

   // Pump rate as a reciprocal multiply by 1/100.
   assign pump_prod = 33'(snap_ff.pump_hold) * 33'(PUMP_RECIP);

   // Decode the snapshot into a result beat.
   always_comb begin
      rsp_in = '0;
      priority if (is_status) begin
         rsp_in.frame_kind        = KIND_STATUS;
         rsp_in.heater_on         = (snap_ff.phase_hold != PHASE_OFF);
         rsp_in.ignition_step     = snap_ff.step_hold;
         rsp_in.battery_decivolts = snap_ff.volt_hold;
         rsp_in.room_decidegrees  = snap_ff.temp_hold;
         rsp_in.fan_speed         = snap_ff.fan_hold;
         rsp_in.pump_count        = snap_ff.pump_hold;
         rsp_in.pump_rate         = pump_prod[PUMP_SHIFT +: 10];
         rsp_in.hours_run         = snap_ff.hours_hold;
         rsp_in.sequence_number   = snap_ff.seq_hold;
         priority if (snap_ff.phase_hold == PHASE_OFF) begin
            rsp_in.run_class = RUN_OFF;
         end else if (snap_ff.fan_hold == 16'd0 && snap_ff.pump_hold == 16'd0) begin
            rsp_in.run_class = RUN_PREPARING;
         end else if (snap_ff.phase_hold == PHASE_START && snap_ff.pump_hold != 16'd0) begin
            rsp_in.run_class = RUN_STARTING;
         end else if (snap_ff.phase_hold == PHASE_HEAT_A ||
                      snap_ff.phase_hold == PHASE_HEAT_B) begin
            rsp_in.run_class = RUN_HEATING;
         end else begin
            rsp_in.run_class = RUN_COOLING;
         end
      end else if (is_basic) begin
         rsp_in.frame_kind = KIND_BASIC;
      end else if (is_abba) begin
         rsp_in.frame_kind = KIND_ABBA;
      end else begin
         rsp_in.frame_kind = KIND_UNKNOWN;
      end
   end

   // Output register valid.
   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (res_load) begin
         rsp_vld_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_vld_in = 1'b0;
      end
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         frm_ff      <= '0;
         snap_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         frm_ff      <= frm_in;
         snap_vld_ff <= snap_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      snap_ff <= snap_in;
      if (res_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

   // The capture count never passes the status frame length.
   a_idx_sat: assert property (@(posedge clock) disable iff (reset)
      frm_ff.byte_index <= STATUS_LEN)
      else $error("byte count passed the status frame length");

   // The last byte of a frame clears the capture state.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      last_acc |=> (frm_ff.byte_index == '0 && frm_ff.lead0 == 8'd0))
      else $error("capture state not cleared after last byte");

   // Frames other than heater status carry only their kind.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.frame_kind != KIND_STATUS) |->
      (rsp_ff.fan_speed == 16'd0 && rsp_ff.pump_rate == 10'd0 &&
       rsp_ff.heater_on == 1'b0 && rsp_ff.run_class == RUN_OFF))
      else $error("non-status frame carries decoded fields");

   // A full snapshot that cannot move holds off the input.
   a_stall: assert property (@(posedge clock) disable iff (reset)
      (snap_vld_ff && rsp_vld_ff && rsp_stall) |-> req_stall)
      else $error("input accepted while snapshot blocked");

endmodule : heater_status_frame_decoder
`default_nettype wire

// ===== tb/sv/heater_status_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// heater_status_frame_decoder_tb: self-checking bench for the frame decoder
//
// Sends notifications one byte per beat and predicts the result of each one
// from a byte-level copy of the capture state. The bench first sends a short
// directed set of frames: run class cases, header and length limits, overlong
// frames and a one-byte frame. It then sends random frames under three idling
// patterns. Every result beat is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module heater_status_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hsfd_pkg::*;

   // Tracks the capture state and holds the decoded frames still owed.
   class frame_scoreboard;
      frame_type   frame_state;
      rsp_type     pending_decodes[$];
      int unsigned mismatches;

      function new();
         frame_state = '0;
         mismatches  = 0;
      endfunction

      task log_mismatch(string what);
         $display("[%0t] MISMATCH: %s", $realtime, what);
         mismatches++;
      endtask

      // Captures one accepted byte; the last byte of a frame yields a decode.
      function void note_beat(req_type beat);
         rsp_type decoded;
         if (frame_state.byte_index < STATUS_LEN) begin
            case (frame_state.byte_index)
               OFS_LEAD0: frame_state.lead0 = beat.rx_byte;
               OFS_LEAD1: frame_state.lead1 = beat.rx_byte;
               OFS_LEAD2: frame_state.lead2 = beat.rx_byte;
               OFS_SEQ:   frame_state.seq_hold = beat.rx_byte;
               OFS_PHASE: frame_state.phase_hold = beat.rx_byte;
               OFS_VOLT:  frame_state.volt_hold = beat.rx_byte;
               OFS_STEP:  frame_state.step_hold = beat.rx_byte;
               OFS_TEMP:  frame_state.temp_hold = beat.rx_byte;
               OFS_FAN_L: frame_state.fan_hold[7:0] = beat.rx_byte;
               OFS_FAN_H: frame_state.fan_hold[15:8] = beat.rx_byte;
               OFS_PMP_L: frame_state.pump_hold[7:0] = beat.rx_byte;
               OFS_PMP_H: frame_state.pump_hold[15:8] = beat.rx_byte;
               OFS_HOURS: frame_state.hours_hold = beat.rx_byte;
               default: ;
            endcase
            frame_state.byte_index = frame_state.byte_index + 1'b1;
         end
         if (!beat.end_of_frame) return;

         // Sort the frame; only a status frame carries decoded fields.
         decoded = '0;
         if (frame_state.byte_index >= STATUS_LEN && frame_state.lead0 == HDR_AA &&
             frame_state.lead1 == HDR_09 && frame_state.lead2 == HDR_FF) begin
            decoded.frame_kind = KIND_STATUS;
            decoded.heater_on  = (frame_state.phase_hold != PHASE_OFF);
            if (frame_state.phase_hold == PHASE_OFF) begin
               decoded.run_class = RUN_OFF;
            end else if (frame_state.fan_hold == 16'h0 && frame_state.pump_hold == 16'h0) begin
               decoded.run_class = RUN_PREPARING;
            end else if (frame_state.phase_hold == PHASE_START &&
                         frame_state.pump_hold != 16'h0) begin
               decoded.run_class = RUN_STARTING;
            end else if (frame_state.phase_hold == PHASE_HEAT_A ||
                         frame_state.phase_hold == PHASE_HEAT_B) begin
               decoded.run_class = RUN_HEATING;
            end else begin
               decoded.run_class = RUN_COOLING;
            end
            decoded.ignition_step     = frame_state.step_hold;
            decoded.battery_decivolts = frame_state.volt_hold;
            decoded.room_decidegrees  = frame_state.temp_hold;
            decoded.fan_speed         = frame_state.fan_hold;
            decoded.pump_count        = frame_state.pump_hold;
            decoded.pump_rate         = 10'(frame_state.pump_hold / 16'd100);
            decoded.hours_run         = frame_state.hours_hold;
            decoded.sequence_number   = frame_state.seq_hold;
         end else if (frame_state.byte_index >= BASIC_LEN && frame_state.lead0 == HDR_AA &&
                      frame_state.lead1 == HDR_55) begin
            decoded.frame_kind = KIND_BASIC;
         end else if (frame_state.byte_index >= BASIC_LEN && frame_state.lead0 == HDR_AB &&
                      frame_state.lead1 == HDR_BA) begin
            decoded.frame_kind = KIND_ABBA;
         end else begin
            decoded.frame_kind = KIND_UNKNOWN;
         end
         pending_decodes.push_back(decoded);
         frame_state = '0;
      endfunction

      task check_field(string name, logic [15:0] got, logic [15:0] want);
         if (got !== want) begin
            log_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
         end
      endtask

      // Compares one accepted result beat with the oldest decode.
      task check_result(rsp_type got);
         rsp_type want;
         if (pending_decodes.size() == 0) begin
            log_mismatch($sformatf("result beat %h with no frame outstanding", got));
            return;
         end
         want = pending_decodes.pop_front();
         check_field("frame_kind", got.frame_kind, want.frame_kind);
         check_field("heater_on", got.heater_on, want.heater_on);
         check_field("run_class", got.run_class, want.run_class);
         check_field("ignition_step", got.ignition_step, want.ignition_step);
         check_field("battery_decivolts", got.battery_decivolts, want.battery_decivolts);
         check_field("room_decidegrees", got.room_decidegrees, want.room_decidegrees);
         check_field("fan_speed", got.fan_speed, want.fan_speed);
         check_field("pump_count", got.pump_count, want.pump_count);
         check_field("pump_rate", got.pump_rate, want.pump_rate);
         check_field("hours_run", got.hours_run, want.hours_run);
         check_field("sequence_number", got.sequence_number, want.sequence_number);
      endtask

      task check_drained();
         if (pending_decodes.size() != 0) begin
            log_mismatch($sformatf("%0d decoded frames never arrived",
                                   pending_decodes.size()));
         end
      endtask
   endclass

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   logic [7:0]  frame_bytes[$];
   frame_scoreboard scoreboard;

   heater_status_frame_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Receiver stalls at random at the rate of the current idling pattern.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Both channels are sampled at the rising edge.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         scoreboard.note_beat(req_data);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         scoreboard.check_result(rsp_data);
      end
   end

   // A negative fill gives random bytes.
   function automatic void fill_frame(int unsigned len, int fill);
      frame_bytes.delete();
      for (int unsigned i = 0; i < len; i++) begin
         frame_bytes.push_back((fill < 0) ? 8'($urandom_range(255)) : 8'(fill));
      end
   endfunction

   function automatic void set_byte(int unsigned ofs, logic [7:0] value);
      if (ofs < frame_bytes.size()) frame_bytes[ofs] = value;
   endfunction

   function automatic void make_status(int unsigned len, int fill, logic [7:0] phase,
                                       logic [15:0] fan, logic [15:0] pump);
      fill_frame(len, fill);
      set_byte(OFS_LEAD0, HDR_AA);
      set_byte(OFS_LEAD1, HDR_09);
      set_byte(OFS_LEAD2, HDR_FF);
      set_byte(OFS_PHASE, phase);
      set_byte(OFS_FAN_L, fan[7:0]);
      set_byte(OFS_FAN_H, fan[15:8]);
      set_byte(OFS_PMP_L, pump[7:0]);
      set_byte(OFS_PMP_H, pump[15:8]);
   endfunction

   function automatic void make_pair_frame(int unsigned len, logic [7:0] h0, logic [7:0] h1);
      fill_frame(len, -1);
      set_byte(OFS_LEAD0, h0);
      set_byte(OFS_LEAD1, h1);
   endfunction

   // Sends the frame one beat per byte, with random gaps before any beat.
   task automatic send_frame();
      for (int unsigned i = 0; i < frame_bytes.size(); i++) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
         req_valid <= 1'b1;
         req_data  <= '{rx_byte: frame_bytes[i], end_of_frame: (i == frame_bytes.size() - 1)};
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
   endtask

   task automatic run_directed();
      // Run classes, with all-zero and all-ones content.
      make_status(52, 8'h00, PHASE_OFF, 16'h0000, 16'h0000);
      send_frame();
      make_status(52, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      send_frame();
      make_status(52, -1, 8'h00, 16'h0000, 16'h0000);
      send_frame();
      make_status(53, -1, PHASE_START, 16'h0000, 16'h1234);
      send_frame();
      make_status(52, -1, PHASE_START, 16'd100, 16'h0000);
      send_frame();
      make_status(54, -1, PHASE_HEAT_A, 16'd2500, 16'd199);
      send_frame();
      make_status(52, -1, PHASE_HEAT_B, 16'd0, 16'd99);
      send_frame();
      make_status(52, -1, PHASE_OFF, 16'hFFFF, 16'hFFFF);
      send_frame();
      // One byte short of a status frame, then overlong frames.
      make_status(51, -1, PHASE_HEAT_A, 16'd3000, 16'd500);
      send_frame();
      make_status(63, -1, PHASE_HEAT_B, 16'd3000, 16'd500);
      send_frame();
      make_status(70, -1, PHASE_START, 16'd1, 16'd1);
      send_frame();
      // Basic and ABBA frames below, at and above the minimum length.
      make_pair_frame(8, HDR_AA, HDR_55);
      send_frame();
      make_pair_frame(7, HDR_AA, HDR_55);
      send_frame();
      make_pair_frame(2, HDR_AA, HDR_55);
      send_frame();
      make_pair_frame(60, HDR_AA, HDR_55);
      send_frame();
      make_pair_frame(8, HDR_AB, HDR_BA);
      send_frame();
      make_pair_frame(16, HDR_AB, HDR_BA);
      send_frame();
      // A frame marked on its first byte.
      fill_frame(1, HDR_AA);
      send_frame();
   endtask

   task automatic run_random_phase(int unsigned min_bytes, int unsigned min_frames);
      int unsigned bytes_sent;
      int unsigned frames_sent;
      int unsigned pick;
      int unsigned len;
      logic [7:0]  phase;
      logic [15:0] fan;
      logic [15:0] pump;
      bytes_sent  = 0;
      frames_sent = 0;
      while (bytes_sent < min_bytes || frames_sent < min_frames) begin
         pick = $urandom_range(99);
         case ($urandom_range(4))
            0:       phase = PHASE_OFF;
            1:       phase = PHASE_START;
            2:       phase = PHASE_HEAT_A;
            3:       phase = PHASE_HEAT_B;
            default: phase = 8'($urandom_range(255));
         endcase
         fan  = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(65535));
         pump = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom_range(65535));
         if (pick < 30) begin
            // Well-formed status frame, now and then overlong.
            len = ($urandom_range(9) < 8) ? $urandom_range(52, 56) : $urandom_range(57, 72);
            make_status(len, -1, phase, fan, pump);
         end else if (pick < 50) begin
            make_pair_frame($urandom_range(2, 16), HDR_AA, HDR_55);
         end else if (pick < 65) begin
            make_pair_frame($urandom_range(2, 16), HDR_AB, HDR_BA);
         end else if (pick < 80) begin
            // Status frame of random length, often cut short, and at times with one header bit broken.
            make_status($urandom_range(24, 60), -1, phase, fan, pump);
            if ($urandom_range(1) == 1) begin
               len = $urandom_range(2);
               pick = $urandom_range(7);
               frame_bytes[len][pick] = ~frame_bytes[len][pick];
            end
         end else begin
            fill_frame($urandom_range(1, 40), -1);
         end
         send_frame();
         bytes_sent += frame_bytes.size();
         frames_sent++;
      end
   endtask

   initial begin
      int unsigned drain_cycles;
      scoreboard = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Sender mostly busy, receiver mostly stalled.
      send_idle_pct  = 6;
      recv_stall_pct = 68;
      run_directed();
      run_random_phase(60, 2);

      // Sender mostly idle, receiver mostly ready.
      send_idle_pct  = 68;
      recv_stall_pct = 6;
      run_random_phase(60, 2);

      // Back to back with no idling.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_phase(60, 2);
      req_valid <= 1'b0;

      drain_cycles = 0;
      while (scoreboard.pending_decodes.size() != 0 && drain_cycles < 20000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (10) @(posedge clock);
      scoreboard.check_drained();
      if (scoreboard.mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(4ms);
      $display("Verification failed");
      $finish;
   end

endmodule : heater_status_frame_decoder_tb
